/* hw/rtl/vbd_pkg.sv */
// Package for the varint blob decoder: widths, status codes, register
// indexes, the blob snapshot type and the target width mask function.
// Depends on nothing; used by every module of the block.
`default_nettype none

package vbd_pkg;

   // Blob format
   localparam int HEADER_BYTES = 3;
   localparam int POS_W        = 24;   // byte position, saturating
   localparam int HDR_W        = 24;   // header shift register
   localparam int COUNT_W      = 23;   // declared data byte count
   localparam int MAG_W        = 64;   // accumulated magnitude
   localparam int BYTE_W       = 8;
   localparam logic [POS_W-1:0] POS_MAX  = 24'hFF_FFFF;
   localparam logic [HDR_W-1:0] SIGN_BIT = 24'h80_0000;

   // Result item packing
   localparam int STATUS_W   = 2;
   localparam int RSP_DATA_W = 72;    // int_value + status, padded to bytes

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_WIDTH_SEL = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_IS_SIGNED = 1'b1;

   localparam logic [1:0] WIDTH_SEL_8  = 2'd0;
   localparam logic [1:0] WIDTH_SEL_16 = 2'd1;
   localparam logic [1:0] WIDTH_SEL_32 = 2'd2;
   localparam logic [1:0] WIDTH_SEL_64 = 2'd3;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_SHORT     = 2'd1,
      STAT_POS_RANGE = 2'd2,
      STAT_NEG_RANGE = 2'd3
   } status_type;

   // Everything the range stage needs from a finished blob
   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             overflow;
      logic             negative;
      logic             short_blob;
   } blob_snap_type;

   // All-ones mask of the target width
   function automatic logic [MAG_W-1:0] width_mask(input logic [1:0] sel);
      logic [MAG_W-1:0] m;
      case (sel)
         WIDTH_SEL_8:  m = 64'h0000_0000_0000_00FF;
         WIDTH_SEL_16: m = 64'h0000_0000_0000_FFFF;
         WIDTH_SEL_32: m = 64'h0000_0000_FFFF_FFFF;
         WIDTH_SEL_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
         default:      m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/vbd_accum.sv */
// Blob accumulator: header decode, byte counting and big-endian magnitude
// shift-accumulate, one byte per accepted item. Uses vbd_pkg.
`default_nettype none

module vbd_accum
   import vbd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_en,
   input  wire logic [BYTE_W-1:0] in_byte,
   input  wire logic              in_last,
   output blob_snap_type          snap
);

   logic [POS_W-1:0]   pos_ff,   pos_in;
   logic [HDR_W-1:0]   hdr_ff,   hdr_in;
   logic [MAG_W-1:0]   mag_ff,   mag_in;
   logic               ovf_ff,   ovf_in;
   logic               neg_ff,   neg_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               in_hdr;
   logic               in_data;
   logic [POS_W-1:0]   data_idx;
   logic [HDR_W-1:0]   hdr_dec;
   logic [BYTE_W-1:0]  data_b;
   logic [POS_W-1:0]   total_after;

   // Phase of the current byte
   assign in_hdr   = pos_ff < POS_W'(HEADER_BYTES);
   assign data_idx = pos_ff - POS_W'(HEADER_BYTES);
   assign in_data  = !in_hdr && (data_idx < {1'b0, count_ff});
   assign data_b   = neg_ff ? ~in_byte : in_byte;

   // Next state for one byte
   always_comb begin
      hdr_in   = hdr_ff;
      neg_in   = neg_ff;
      count_in = count_ff;
      mag_in   = mag_ff;
      ovf_in   = ovf_ff;
      hdr_dec  = '0;
      if (in_hdr) begin
         hdr_in = {hdr_ff[HDR_W-BYTE_W-1:0], in_byte};
         if (pos_ff == POS_W'(HEADER_BYTES - 1)) begin
            neg_in   = (hdr_in & SIGN_BIT) == '0;
            hdr_dec  = neg_in ? ~hdr_in : hdr_in;
            count_in = hdr_dec[COUNT_W-1:0];
         end
      end else if (in_data) begin
         if (mag_ff[MAG_W-1:MAG_W-BYTE_W] != '0) begin
            ovf_in = 1'b1;
         end
         mag_in = {mag_ff[MAG_W-BYTE_W-1:0], data_b};
      end
      pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POS_W'(1);
   end

   // Snapshot as it stands after this byte
   assign total_after     = pos_in;
   assign snap.mag        = mag_in;
   assign snap.overflow   = ovf_in;
   assign snap.negative   = neg_in;
   assign snap.short_blob = (total_after < POS_W'(HEADER_BYTES)) ||
                            ((total_after - POS_W'(HEADER_BYTES)) < {1'b0, count_in});

   // State registers; the last byte returns the blob state to reset
   always_ff @(posedge clock) begin
      if (reset || (in_en && in_last)) begin
         pos_ff   <= '0;
         hdr_ff   <= '0;
         mag_ff   <= '0;
         ovf_ff   <= 1'b0;
         neg_ff   <= 1'b0;
         count_ff <= '0;
      end else if (in_en) begin
         pos_ff   <= pos_in;
         hdr_ff   <= hdr_in;
         mag_ff   <= mag_in;
         ovf_ff   <= ovf_in;
         neg_ff   <= neg_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/vbd_range.sv */
// Range check and cast of a finished blob to the configured target type.
// Pure logic between the snapshot register and the result register. Uses vbd_pkg.
`default_nettype none

module vbd_range
   import vbd_pkg::*;
(
   input  wire blob_snap_type     snap,
   input  wire logic [1:0]        width_sel,
   input  wire logic              is_signed,
   output logic [MAG_W-1:0]       cast_value,
   output status_type             status
);

   logic [MAG_W-1:0] mask;
   logic [MAG_W-1:0] half;
   logic [MAG_W-1:0] pos_max;
   logic [MAG_W-1:0] neg_max;
   logic [MAG_W-1:0] neg_val;

   assign mask    = width_mask(width_sel);
   assign half    = {1'b0, mask[MAG_W-1:1]};
   assign pos_max = is_signed ? half : mask;
   assign neg_max = is_signed ? half + MAG_W'(1) : '0;
   assign neg_val = (~snap.mag + MAG_W'(1)) & mask;

   // Status priority: short blob, then range by sign
   always_comb begin
      cast_value = '0;
      status     = STAT_OK;
      if (snap.short_blob) begin
         status = STAT_SHORT;
      end else if (!snap.negative) begin
         if (snap.overflow || snap.mag > pos_max) begin
            status = STAT_POS_RANGE;
         end else begin
            cast_value = snap.mag;
         end
      end else begin
         if (snap.overflow || snap.mag > neg_max) begin
            status = STAT_NEG_RANGE;
         end else begin
            cast_value = neg_val;
         end
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/varint_blob_to_integer_decoder_core.sv */
// Top level of the varint blob decoder: configuration registers, the
// snapshot and result registers and the stream handshake.
// Depends on vbd_pkg, vbd_accum and vbd_range.
//
//   channel  dir  handshake          payload
//   req_     in   tvalid/tready      tdata[7:0] data_byte, tlast last_byte
//   rsp_     out  tvalid/tready      tdata[63:0] value, [65:64] status
//   csr_     in   we                 index (0 width sel, 1 signed), wdata
//
// One byte is accepted every cycle while the result side keeps up.
// A last byte's result passes through the snapshot register, then the
// result register after the range check.
// Reset (synchronous) clears the blob state and both valid flags and sets the config to 64-bit signed.
// A stalled result holds; bytes keep flowing until the snapshot stage is full.
`default_nettype none

module varint_blob_to_integer_decoder_core
   import vbd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Input items
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [BYTE_W-1:0]      req_tdata,   // [7:0] data_byte
   input  wire logic                   req_tlast,   // last_byte
   // Result items
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // [63:0] value, [65:64] status
   // Configuration
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [1:0]       tgt_width_ff;
   logic             tgt_signed_ff;
   logic             s1_valid_ff;
   blob_snap_type    s1_snap_ff;
   logic             rsp_valid_ff;
   logic [MAG_W-1:0] rsp_value_ff;
   status_type       rsp_status_ff;

   logic             in_en;
   logic             out_en;
   blob_snap_type    snap;
   logic [MAG_W-1:0] value_in;
   status_type       status_in;

   // Handshake
   assign out_en     = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_en;
   assign in_en      = req_tvalid && req_tready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_width_ff  <= WIDTH_SEL_64;
         tgt_signed_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET_WIDTH_SEL: tgt_width_ff  <= csr_wdata[1:0];
            CSR_TARGET_IS_SIGNED: tgt_signed_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   vbd_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .in_en   (in_en),
      .in_byte (req_tdata),
      .in_last (req_tlast),
      .snap    (snap)
   );

   // Snapshot register: one finished blob
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_en && req_tlast) begin
         s1_valid_ff <= 1'b1;
      end else if (out_en) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_en && req_tlast) begin
         s1_snap_ff <= snap;
      end
   end

   vbd_range u_range (
      .snap       (s1_snap_ff),
      .width_sel  (tgt_width_ff),
      .is_signed  (tgt_signed_ff),
      .cast_value (value_in),
      .status     (status_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && s1_valid_ff) begin
         rsp_value_ff  <= value_in;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - MAG_W - STATUS_W){1'b0}}, rsp_status_ff, rsp_value_ff};

endmodule

`default_nettype wire

/* hw/rtl/vbd_checker.sv */
// Port-level checks for the varint blob decoder, bound to the top level.
// Depends on vbd_pkg and varint_blob_to_integer_decoder_core.
`default_nettype none

module vbd_checker
   import vbd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  req_tlast,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result item holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // An error status never carries a value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[MAG_W+STATUS_W-1:MAG_W] != STAT_OK) |->
      rsp_tdata[MAG_W-1:0] == '0)
      else $error("error status with nonzero value");

   // Padding bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:MAG_W+STATUS_W] == '0)
      else $error("result padding not zero");

   // A last byte is followed by a valid result item
   a_last_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |-> ##2 rsp_tvalid)
      else $error("no result after last byte");

   // Nothing comes out right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind varint_blob_to_integer_decoder_core vbd_checker u_vbd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
